### rtl/nrd_pkg.sv
// ----------------------------------------------------------------------------
// nrd_pkg
// Shared constants, codes and helper functions of the nested record deframer.
// ----------------------------------------------------------------------------
package nrd_pkg;

  localparam int MAX_DEPTH_DEF     = 16;
  localparam int LENGTH_DIGITS_DEF = 8;

  localparam int LEN_W  = 42;
  localparam int OFS_W  = 32;
  localparam int END_W  = 48;
  localparam int VAL_W  = 64;
  localparam int KIND_W = 4;
  localparam int STAT_W = 3;
  localparam int DEPO_W = 5;
  localparam int TAG_N  = 3;

  localparam logic [KIND_W-1:0] K_STR = 4'd0;
  localparam logic [KIND_W-1:0] K_INT = 4'd1;
  localparam logic [KIND_W-1:0] K_FLO = 4'd2;
  localparam logic [KIND_W-1:0] K_BOO = 4'd3;
  localparam logic [KIND_W-1:0] K_NUL = 4'd4;
  localparam logic [KIND_W-1:0] K_BST = 4'd5;
  localparam logic [KIND_W-1:0] K_HEX = 4'd6;
  localparam logic [KIND_W-1:0] K_OBJ = 4'd7;
  localparam logic [KIND_W-1:0] K_UNK = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_DIGIT = 3'd1;
  localparam logic [STAT_W-1:0] ST_VALUE = 3'd2;
  localparam logic [STAT_W-1:0] ST_TRUNC = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVFL  = 3'd4;

  // stack control between the parser and the stack memory
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  // map a 3-byte tag to its kind code
  function automatic logic [KIND_W-1:0] decode_tag(input logic [23:0] t);
    logic [KIND_W-1:0] k;
    k = K_UNK;
    case (t)
      {8'h53, 8'h54, 8'h52}: k = K_STR;
      {8'h49, 8'h4E, 8'h54}: k = K_INT;
      {8'h46, 8'h4C, 8'h4F}: k = K_FLO;
      {8'h42, 8'h4F, 8'h4F}: k = K_BOO;
      {8'h4E, 8'h55, 8'h4C}: k = K_NUL;
      {8'h42, 8'h53, 8'h54}: k = K_BST;
      {8'h48, 8'h45, 8'h58}: k = K_HEX;
      {8'h4F, 8'h42, 8'h4A}: k = K_OBJ;
      default:               k = K_UNK;
    endcase
    return k;
  endfunction

  // base-36 digit: bit 6 flags a valid digit, bits 5:0 hold its value
  function automatic logic [6:0] digit36(input logic [7:0] b);
    logic [6:0] r;
    r = 7'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h7A]}) begin
      r = {1'b1, 6'(b - 8'h61 + 8'd10)};
    end else if (b inside {[8'h41:8'h5A]}) begin
      r = {1'b1, 6'(b - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

endpackage

### rtl/nrd_stack.sv
// ----------------------------------------------------------------------------
// nrd_stack
// End-offset stack in a synchronous memory, with the top entry cached.
// ----------------------------------------------------------------------------
module nrd_stack #(
  parameter int MAX_DEPTH = nrd_pkg::MAX_DEPTH_DEF,
  parameter int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nrd_pkg::stk_ctl_t        ctl,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic [IDX_W-1:0]         rd_idx,
  input  logic [nrd_pkg::END_W-1:0] push_data,
  output logic [nrd_pkg::END_W-1:0] top
);
  import nrd_pkg::*;

  logic [END_W-1:0] mem [MAX_DEPTH];
  logic [END_W-1:0] rd_data_r;
  logic             rd_pend_r;
  logic [END_W-1:0] top_r;

  // write pushes, read the new top after a pop
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_idx] <= push_data;
    end
    rd_data_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= ctl.pop;
    end
  end

  // refresh cached top: a push is newer than a pending read
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      top_r <= push_data;
    end else if (rd_pend_r) begin
      top_r <= rd_data_r;
    end
  end

  assign top = top_r;

endmodule

### rtl/nested_record_deframer.sv
// ----------------------------------------------------------------------------
// nested_record_deframer
// Cuts a byte stream into tagged records and reports each record, each object header and each error.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_     | in  | tdata: data_byte; tlast: end_of_message
//  out_    | out | tdata: report fields; tuser: record_kind; tlast: message_done
//
//  One byte per cycle while in_tready is high; the parser is combinational,
//  and the report is registered in the output register when its byte is taken.
//  The end-offset stack lives in a one-port-read memory; a pop reads the new
//  top through rd_data_r into the cached top, well before the next record start.
//  Reset is synchronous, active low; the stack memory needs no clearing.
//  in_tready drops only while a held report is not taken.
// ----------------------------------------------------------------------------
module nested_record_deframer #(
  parameter int MAX_DEPTH     = nrd_pkg::MAX_DEPTH_DEF,
  parameter int LENGTH_DIGITS = nrd_pkg::LENGTH_DIGITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic [191:0] out_tdata,  // [41:0] name_length, [83:42] value_length,
                                   // [115:84] record_offset, [120:116] nesting_depth,
                                   // [184:121] integer_value, [187:185] status, rest 0
  output logic [3:0]   out_tuser,  // [3:0] record_kind
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready
);
  import nrd_pkg::*;

  localparam int HDR_LEN = TAG_N + 2 * LENGTH_DIGITS;
  localparam int FPOS_W  = $clog2(HDR_LEN + 1);
  localparam int DEP_W   = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [1:0] {PH_HEADER, PH_NAME, PH_VALUE} phase_t;

  // parser state
  logic [OFS_W-1:0]  byte_off_r,  byte_off_nxt;
  logic [OFS_W-1:0]  rec_start_r, rec_start_nxt;
  logic [FPOS_W-1:0] fpos_r,      fpos_nxt;
  logic [LEN_W-1:0]  seg_r,       seg_nxt;
  phase_t            phase_r,     phase_nxt;
  logic [KIND_W-1:0] kind_r,      kind_nxt;
  logic [LEN_W-1:0]  nlen_r,      nlen_nxt;
  logic [LEN_W-1:0]  vlen_r,      vlen_nxt;
  logic [VAL_W-1:0]  acc_r,       acc_nxt;
  logic              neg_r,       neg_nxt;
  logic              pt_r,        pt_nxt;
  logic [DEP_W-1:0]  depth_r,     depth_nxt;
  logic              stopped_r,   stopped_nxt;

  // report and output register
  logic              rep;
  logic [STAT_W-1:0] rep_status;
  logic [DEP_W-1:0]  rep_depth;
  logic [VAL_W-1:0]  rep_ival;
  logic [KIND_W-1:0] rep_kind;
  logic [LEN_W-1:0]  rep_nlen, rep_vlen;
  logic [OFS_W-1:0]  rep_ofs;
  logic              out_valid_r;
  logic [191:0]      out_data_r;
  logic [3:0]        out_user_r;
  logic              out_last_r;

  // stack interface
  stk_ctl_t          stk_ctl;
  logic [IDX_W-1:0]  stk_wr_idx, stk_rd_idx;
  logic [END_W-1:0]  stk_push_data, stk_top;

  logic              in_fire;
  logic              do_after;
  logic              first;
  logic              is_digit, is_sign;
  logic [6:0]        d36;
  logic [7:0]        b;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign d36       = digit36(b);
  assign is_digit  = b inside {[8'h30:8'h39]};
  assign is_sign   = (b == 8'h2D) || (b == 8'h2B);

  nrd_stack #(.MAX_DEPTH(MAX_DEPTH), .IDX_W(IDX_W)) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stk_ctl),
    .wr_idx    (stk_wr_idx),
    .rd_idx    (stk_rd_idx),
    .push_data (stk_push_data),
    .top       (stk_top)
  );

  // parse one byte
  always_comb begin
    byte_off_nxt  = byte_off_r;
    rec_start_nxt = rec_start_r;
    fpos_nxt      = fpos_r;
    seg_nxt       = seg_r;
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    nlen_nxt      = nlen_r;
    vlen_nxt      = vlen_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    pt_nxt        = pt_r;
    depth_nxt     = depth_r;
    stopped_nxt   = stopped_r;
    rep           = 1'b0;
    rep_status    = ST_OK;
    rep_depth     = depth_r;
    rep_ival      = '0;
    do_after      = 1'b0;
    first         = 1'b0;
    stk_ctl       = '0;
    stk_wr_idx    = IDX_W'(depth_r);
    stk_rd_idx    = '0;
    stk_push_data = '0;

    if (in_fire && !stopped_r) begin
      case (phase_r)
        PH_HEADER: begin
          // open a record, drop one finished level
          if (fpos_r == '0) begin
            rec_start_nxt = byte_off_r;
            nlen_nxt = '0;
            vlen_nxt = '0;
            acc_nxt  = '0;
            neg_nxt  = 1'b0;
            pt_nxt   = 1'b0;
            kind_nxt = K_UNK;
            if (depth_r != '0 && {16'd0, byte_off_r} >= stk_top) begin
              depth_nxt   = depth_r - 1'b1;
              stk_ctl.pop = 1'b1;
              stk_rd_idx  = IDX_W'(depth_r - DEP_W'(2));
            end
          end
          if (fpos_r < FPOS_W'(TAG_N)) begin
            acc_nxt = {40'd0, acc_nxt[15:0], b};
            if (fpos_r == FPOS_W'(TAG_N - 1)) begin
              kind_nxt = decode_tag(acc_nxt[23:0]);
            end
            fpos_nxt = fpos_r + 1'b1;
          end else if (!d36[6]) begin
            rep         = 1'b1;
            rep_status  = ST_DIGIT;
            rep_depth   = depth_nxt;
            stopped_nxt = 1'b1;
          end else begin
            if (fpos_r < FPOS_W'(TAG_N + LENGTH_DIGITS)) begin
              nlen_nxt = (nlen_r << 5) + (nlen_r << 2) + LEN_W'(d36[5:0]);
            end else begin
              vlen_nxt = (vlen_r << 5) + (vlen_r << 2) + LEN_W'(d36[5:0]);
            end
            fpos_nxt = fpos_r + 1'b1;
          end
          // header complete
          if (!stopped_nxt && fpos_nxt >= FPOS_W'(HDR_LEN)) begin
            fpos_nxt = '0;
            acc_nxt  = '0;
            if (nlen_nxt != '0) begin
              phase_nxt = PH_NAME;
              seg_nxt   = nlen_nxt;
            end else begin
              do_after = 1'b1;
            end
          end
        end
        PH_NAME: begin
          seg_nxt = seg_r - 1'b1;
          if (seg_nxt == '0) begin
            do_after = 1'b1;
          end
        end
        default: begin
          // check one value byte
          first = (seg_r == vlen_r);
          if (kind_r == K_INT) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1);
            if (is_sign && first) begin
              if (b == 8'h2D) begin
                neg_nxt = 1'b1;
              end
            end else if (is_digit) begin
              acc_nxt = acc_nxt + VAL_W'(b[3:0]);
            end else begin
              stopped_nxt = 1'b1;
            end
          end else if (kind_r == K_FLO) begin
            if (!((is_sign && first) || is_digit)) begin
              if ((b == 8'h2E || b == 8'h2C) && !pt_r) begin
                pt_nxt = 1'b1;
              end else begin
                stopped_nxt = 1'b1;
              end
            end
          end else if (kind_r == K_BOO && first) begin
            if (is_digit) begin
              acc_nxt = VAL_W'(b[3:0]);
            end else if (!is_sign) begin
              stopped_nxt = 1'b1;
            end
          end
          if (stopped_nxt) begin
            rep        = 1'b1;
            rep_status = ST_VALUE;
          end else begin
            seg_nxt = seg_r - 1'b1;
            if (seg_nxt == '0) begin
              phase_nxt = PH_HEADER;
              rep       = 1'b1;
              if (kind_r == K_INT) begin
                rep_ival = neg_nxt ? (VAL_W'(0) - acc_nxt) : acc_nxt;
              end else if (kind_r == K_BOO) begin
                rep_ival = acc_nxt;
              end
            end
          end
        end
      endcase

      // header or name done: report an object, enter the value, or report an empty value
      if (do_after) begin
        phase_nxt = PH_HEADER;
        rep_depth = depth_nxt;
        if (kind_nxt == K_OBJ) begin
          rep = 1'b1;
          if (rec_start_nxt != '0) begin
            if (depth_nxt >= DEP_W'(MAX_DEPTH)) begin
              rep_status  = ST_OVFL;
              stopped_nxt = 1'b1;
            end else begin
              stk_ctl.push  = 1'b1;
              stk_wr_idx    = IDX_W'(depth_nxt);
              stk_push_data = END_W'({16'd0, byte_off_r}) + END_W'(1) + END_W'(vlen_nxt);
              depth_nxt     = depth_nxt + 1'b1;
            end
          end
        end else if (vlen_nxt != '0) begin
          phase_nxt = PH_VALUE;
          seg_nxt   = vlen_nxt;
          acc_nxt   = '0;
        end else begin
          acc_nxt = '0;
          rep     = 1'b1;
        end
      end
    end

    // report fields as gathered so far
    rep_kind = kind_nxt;
    rep_nlen = nlen_nxt;
    rep_vlen = vlen_nxt;
    rep_ofs  = rec_start_nxt;

    // close the message
    if (in_fire) begin
      if (in_tlast) begin
        if (!rep && !stopped_r) begin
          rep        = 1'b1;
          rep_status = ST_TRUNC;
          rep_depth  = depth_nxt;
          rep_ival   = '0;
        end
        byte_off_nxt  = '0;
        rec_start_nxt = '0;
        fpos_nxt      = '0;
        seg_nxt       = '0;
        phase_nxt     = PH_HEADER;
        kind_nxt      = '0;
        nlen_nxt      = '0;
        vlen_nxt      = '0;
        acc_nxt       = '0;
        neg_nxt       = 1'b0;
        pt_nxt        = 1'b0;
        depth_nxt     = '0;
        stopped_nxt   = 1'b0;
      end else begin
        byte_off_nxt = byte_off_r + 1'b1;
      end
    end
  end

  // hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_off_r  <= '0;
      rec_start_r <= '0;
      fpos_r      <= '0;
      seg_r       <= '0;
      phase_r     <= PH_HEADER;
      kind_r      <= '0;
      nlen_r      <= '0;
      vlen_r      <= '0;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      pt_r        <= 1'b0;
      depth_r     <= '0;
      stopped_r   <= 1'b0;
    end else begin
      byte_off_r  <= byte_off_nxt;
      rec_start_r <= rec_start_nxt;
      fpos_r      <= fpos_nxt;
      seg_r       <= seg_nxt;
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      nlen_r      <= nlen_nxt;
      vlen_r      <= vlen_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      pt_r        <= pt_nxt;
      depth_r     <= depth_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

  // load the output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && rep) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && rep) begin
      out_data_r <= {4'd0, rep_status, rep_ival, DEPO_W'(rep_depth), rep_ofs,
                     rep_vlen, rep_nlen};
      out_user_r <= rep_kind;
      out_last_r <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEP_W'(MAX_DEPTH))
    else $error("stack depth beyond limit");

  a_eom_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> byte_off_r == '0 && depth_r == '0 && !stopped_r)
    else $error("state not cleared at message end");

  a_quiet_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && stopped_r |-> !rep)
    else $error("report while stopped");

  a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(stk_ctl.push && stk_ctl.pop))
    else $error("push and pop together");
`endif

endmodule
